/* sv/tpdc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch point decode and calibrate package
// Shared widths, field codes, register indexes, state type and the request
// and response bundles of the serial divider.
// ----------------------------------------------------------------------------
package tpdc_pkg;

  // Widths of the data paths.
  localparam int DataW    = 32;
  localparam int ByteW    = 8;
  localparam int NibW     = 4;
  localparam int CoordW   = 12;
  localparam int SumW     = 15;
  localparam int CntW     = 3;
  localparam int FracBits = 16;
  localparam int CfgIdxW  = 8;
  localparam int DivCntW  = 6;

  // Default upper bound on the contacts averaged per scan.
  localparam int MaxPointsDef = 1;

  // Field codes of a point record.
  localparam logic [NibW-1:0]  EventContact = 4'h8;
  localparam logic [NibW-1:0]  TouchIdNone  = 4'hF;
  localparam logic [ByteW-1:0] FingerMax    = 8'd5;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_VERTICAL = 8'd0,
    CFG_OFFSET_X = 8'd1,
    CFG_RATIO_X  = 8'd2,
    CFG_OFFSET_Y = 8'd3,
    CFG_RATIO_Y  = 8'd4
  } cfg_idx_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_AVG,
    ST_CAL,
    ST_DONE
  } state_e;

  // Request to the serial divider.
  typedef struct packed {
    logic             start;
    logic             signed_mode;
    logic [DataW-1:0] dividend;
    logic [DataW-1:0] divisor;
  } div_req_t;

  // Response of the serial divider.
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DataW-1:0] quotient;
  } div_rsp_t;

endpackage

/* sv/tpdc_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch point decode and calibrate channels
// Point record input, result output and configuration write channels, each
// with valid, ready and its payload.
// ----------------------------------------------------------------------------

// Point record channel.
interface tpdc_in_if;
  logic                          valid;
  logic                          ready;
  logic [tpdc_pkg::ByteW-1:0]    finger_count;
  logic [tpdc_pkg::ByteW-1:0]    x_high_byte;
  logic [tpdc_pkg::ByteW-1:0]    x_low_byte;
  logic [tpdc_pkg::ByteW-1:0]    y_high_byte;
  logic [tpdc_pkg::ByteW-1:0]    y_low_byte;
  logic                          last_point;

  modport source (
    output valid, finger_count, x_high_byte, x_low_byte, y_high_byte, y_low_byte,
           last_point,
    input  ready
  );
  modport sink (
    input  valid, finger_count, x_high_byte, x_low_byte, y_high_byte, y_low_byte,
           last_point,
    output ready
  );
endinterface

// Result channel.
interface tpdc_out_if;
  logic                              valid;
  logic                              ready;
  logic                              touched;
  logic signed [tpdc_pkg::DataW-1:0] pos_x;
  logic signed [tpdc_pkg::DataW-1:0] pos_y;

  modport source (output valid, touched, pos_x, pos_y, input ready);
  modport sink (input valid, touched, pos_x, pos_y, output ready);
endinterface

// Configuration write channel.
interface tpdc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [tpdc_pkg::CfgIdxW-1:0] index;
  logic [tpdc_pkg::DataW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/tpdc_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch point decode and calibrate serial divider
// Restoring divider that retires one quotient bit per cycle, with optional
// signed operands and a truncating, wrapping signed result.
// ----------------------------------------------------------------------------
module tpdc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tpdc_pkg::div_req_t req_i,
  output tpdc_pkg::div_rsp_t rsp_o
);

  localparam int W = tpdc_pkg::DataW;

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [tpdc_pkg::DivCntW-1:0]   cnt_q, cnt_d;
  logic [W-1:0]                   rem_q, rem_d;
  logic [W-1:0]                   quo_q, quo_d;
  logic [W-1:0]                   dvs_q, dvs_d;
  logic                           neg_q, neg_d;
  logic [W-1:0]                   res_q, res_d;
  logic                           a_neg, b_neg;
  logic [W:0]                     shifted;
  logic [W:0]                     diff;

  // Start, restoring steps (shift in the next dividend bit and try the subtract) and the final sign fix.
  always_comb begin
    a_neg   = req_i.signed_mode & req_i.dividend[W-1];
    b_neg   = req_i.signed_mode & req_i.divisor[W-1];
    shifted = {rem_q, quo_q[W-1]};
    diff    = shifted - {1'b0, dvs_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    neg_d   = neg_q;
    res_d   = res_q;
    if (req_i.start) begin
      // Operands are taken as magnitudes; the sign is restored at the end.
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = a_neg ? (~req_i.dividend + W'(1)) : req_i.dividend;
      dvs_d  = b_neg ? (~req_i.divisor + W'(1)) : req_i.divisor;
      neg_d  = a_neg ^ b_neg;
    end else if (busy_q) begin
      if (cnt_q == tpdc_pkg::DivCntW'(W)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        res_d  = neg_q ? (~quo_q + W'(1)) : quo_q;
      end else begin
        cnt_d = cnt_q + tpdc_pkg::DivCntW'(1);
        if (!diff[W]) begin
          rem_d = diff[W-1:0];
          quo_d = {quo_q[W-2:0], 1'b1};
        end else begin
          rem_d = shifted[W-1:0];
          quo_d = {quo_q[W-2:0], 1'b0};
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Data path registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
    res_q <= res_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = res_q;

endmodule

/* sv/touch_point_decode_calibrate_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch point decode and calibrate core
// Decodes the point records of a touch scan, averages the kept contacts and
// applies the per-axis calibration with serial signed division.
// ----------------------------------------------------------------------------
// Usage: point records arrive on in_i, one request per record; results leave
// on out_o, one request per scan, on the record flagged last_point. Register
// writes arrive on cfg_i (index 0 vertical screen, 1 x offset, 2 x ratio,
// 3 y offset, 4 y ratio) and are always taken; write them only while idle.
// A record that is not the last of a scan is taken whenever the core is idle.
// The last record of a scan with a touch starts two restoring dividers, one
// per axis, that retire one bit a cycle: the averages come first, then the
// calibration divisions, whose quotients are held as the pending result and
// moved to the output register before the next record is taken. A scan end
// without a touch loads a zero pending result and then the output register.
// The result sits in an output register; while the receiver stalls, records
// of the next scan are still taken, and only the next scan end waits for the
// register to free. Reset clears the sums, the contact count and the output
// valid, and loads the registers with vertical screen 1 and all others 0.
// ----------------------------------------------------------------------------
module touch_point_decode_calibrate_core #(
  parameter int MaxPoints = tpdc_pkg::MaxPointsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tpdc_in_if.sink    in_i,
  tpdc_out_if.source out_o,
  tpdc_cfg_if.sink   cfg_i
);

  localparam int W  = tpdc_pkg::DataW;
  localparam int SW = tpdc_pkg::SumW;
  localparam int CW = tpdc_pkg::CntW;
  localparam int DW = tpdc_pkg::CoordW;

  tpdc_pkg::state_e   state_q, state_d;
  tpdc_pkg::div_req_t req_x, req_y;
  tpdc_pkg::div_rsp_t rsp_x, rsp_y;

  logic          vertical_q;
  logic [W-1:0]  offset_x_q, ratio_x_q, offset_y_q, ratio_y_q;
  logic [SW-1:0] sum_x_q, sum_y_q, sum_x_acc, sum_y_acc;
  logic [CW-1:0] contacts_q, contacts_acc;
  logic [DW-1:0] avg_x_q, avg_y_q;
  logic [DW-1:0] raw_a, raw_b, add_x, add_y;
  logic          res_touched_q;
  logic [W-1:0]  res_x_q, res_y_q;
  logic          out_valid_q, out_touched_q;
  logic [W-1:0]  out_x_q, out_y_q;
  logic          in_fire, out_fire, keep, good;
  logic          load_zero, load_cal, load_out, ratio_x_zero, ratio_y_zero;

  assign in_fire  = in_i.valid & in_i.ready;
  assign out_fire = out_valid_q & out_o.ready;

  // Record decode: keep a contact record with a real touch id while room is left.
  always_comb begin
    keep = (in_i.x_high_byte[7:4] == tpdc_pkg::EventContact) &&
           (in_i.y_high_byte[7:4] != tpdc_pkg::TouchIdNone) &&
           (contacts_q < CW'(MaxPoints));
    raw_a = {in_i.x_high_byte[3:0], in_i.x_low_byte};
    raw_b = {in_i.y_high_byte[3:0], in_i.y_low_byte};
    add_x = vertical_q ? raw_a : raw_b;
    add_y = vertical_q ? raw_b : raw_a;
    sum_x_acc    = sum_x_q + (keep ? SW'(add_x) : '0);
    sum_y_acc    = sum_y_q + (keep ? SW'(add_y) : '0);
    contacts_acc = contacts_q + CW'(keep);
    good = (in_i.finger_count != '0) && (in_i.finger_count <= tpdc_pkg::FingerMax) &&
           (contacts_acc != '0);
    ratio_x_zero = (ratio_x_q == '0);
    ratio_y_zero = (ratio_y_q == '0);
  end

  // Sequencer: next state, divider requests and register loads.
  always_comb begin
    state_d    = state_q;
    in_i.ready = (state_q == tpdc_pkg::ST_IDLE);
    req_x      = '0;
    req_y      = '0;
    load_zero  = 1'b0;
    load_cal   = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      tpdc_pkg::ST_IDLE: begin
        if (in_fire && in_i.last_point) begin
          if (good) begin
            // Average over the kept contacts.
            req_x.start    = 1'b1;
            req_x.dividend = W'(sum_x_acc);
            req_x.divisor  = W'(contacts_acc);
            req_y.start    = 1'b1;
            req_y.dividend = W'(sum_y_acc);
            req_y.divisor  = W'(contacts_acc);
            state_d        = tpdc_pkg::ST_AVG;
          end else begin
            load_zero = 1'b1;
            state_d   = tpdc_pkg::ST_DONE;
          end
        end
      end
      tpdc_pkg::ST_AVG: begin
        if (rsp_x.done) begin
          // Calibrate: ((avg << 16) - offset) / ratio, signed.
          req_x.start       = 1'b1;
          req_x.signed_mode = 1'b1;
          req_x.dividend    = (W'(rsp_x.quotient[DW-1:0]) << tpdc_pkg::FracBits) -
                              offset_x_q;
          req_x.divisor     = ratio_x_q;
          req_y.start       = 1'b1;
          req_y.signed_mode = 1'b1;
          req_y.dividend    = (W'(rsp_y.quotient[DW-1:0]) << tpdc_pkg::FracBits) -
                              offset_y_q;
          req_y.divisor     = ratio_y_q;
          state_d           = tpdc_pkg::ST_CAL;
        end
      end
      tpdc_pkg::ST_CAL: begin
        if (rsp_x.done) begin
          load_cal = 1'b1;
          state_d  = tpdc_pkg::ST_DONE;
        end
      end
      tpdc_pkg::ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = tpdc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tpdc_pkg::ST_IDLE;
      end
    endcase
  end

  // One divider per axis; both run in lockstep.
  tpdc_div u_div_x (.clk_i, .rst_ni, .req_i(req_x), .rsp_o(rsp_x));
  tpdc_div u_div_y (.clk_i, .rst_ni, .req_i(req_y), .rsp_o(rsp_y));

  // Configuration writes are always taken.
  assign cfg_i.ready = 1'b1;

  // Control state, scan accumulators and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tpdc_pkg::ST_IDLE;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      contacts_q  <= '0;
      out_valid_q <= 1'b0;
      vertical_q  <= 1'b1;
      offset_x_q  <= '0;
      ratio_x_q   <= '0;
      offset_y_q  <= '0;
      ratio_y_q   <= '0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        sum_x_q    <= in_i.last_point ? '0 : sum_x_acc;
        sum_y_q    <= in_i.last_point ? '0 : sum_y_acc;
        contacts_q <= in_i.last_point ? '0 : contacts_acc;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        case (cfg_i.index)
          tpdc_pkg::CFG_VERTICAL: vertical_q <= cfg_i.data[0];
          tpdc_pkg::CFG_OFFSET_X: offset_x_q <= cfg_i.data;
          tpdc_pkg::CFG_RATIO_X:  ratio_x_q  <= cfg_i.data;
          tpdc_pkg::CFG_OFFSET_Y: offset_y_q <= cfg_i.data;
          tpdc_pkg::CFG_RATIO_Y:  ratio_y_q  <= cfg_i.data;
          default: begin
          end
        endcase
      end
    end
  end

  // Averages, pending result and output register.
  always_ff @(posedge clk_i) begin
    if ((state_q == tpdc_pkg::ST_AVG) && rsp_x.done) begin
      avg_x_q <= rsp_x.quotient[DW-1:0];
      avg_y_q <= rsp_y.quotient[DW-1:0];
    end
    if (load_zero) begin
      res_touched_q <= 1'b0;
      res_x_q       <= '0;
      res_y_q       <= '0;
    end else if (load_cal) begin
      // A zero ratio passes the averaged coordinate through.
      res_touched_q <= 1'b1;
      res_x_q       <= ratio_x_zero ? W'(avg_x_q) : rsp_x.quotient;
      res_y_q       <= ratio_y_zero ? W'(avg_y_q) : rsp_y.quotient;
    end
    if (load_out) begin
      out_touched_q <= res_touched_q;
      out_x_q       <= res_x_q;
      out_y_q       <= res_y_q;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.touched = out_touched_q;
  assign out_o.pos_x   = out_x_q;
  assign out_o.pos_y   = out_y_q;

endmodule

/* dv/touch_point_decode_calibrate_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch point decode and calibrate core testbench
// Sends point records of whole scans to the core under several calibration
// settings and checks every scan report against a local prediction of the
// contact averaging and the fixed point calibration. Both sides idle and
// stall at random, and one long receiver hold-off lets the core fill up.
// ----------------------------------------------------------------------------
module touch_point_decode_calibrate_core_test;
  import tpdc_pkg::*;

  localparam int MaxPoints      = MaxPointsDef;
  localparam int RandomPerPhase = 125;
  localparam int RandomPhases   = 4;
  localparam int HoldCycles     = 400;
  localparam int SettleCycles   = 100;
  localparam int DrainLimit     = 20000;
  localparam int PrintCap       = 100;
  localparam int TimeLimitNs    = 4_000_000;

  // Register indexes outside the register list, which the core must ignore.
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 8'd5;
  localparam logic [CfgIdxW-1:0] CfgIdxTop   = 8'hFF;

  // One point record as it travels on the record channel.
  typedef struct {
    logic [ByteW-1:0] fingers;
    logic [ByteW-1:0] xh;
    logic [ByteW-1:0] xl;
    logic [ByteW-1:0] yh;
    logic [ByteW-1:0] yl;
    logic             last;
  } point_rec_t;

  // One scan report.
  typedef struct {
    logic                    touched;
    logic signed [DataW-1:0] pos_x;
    logic signed [DataW-1:0] pos_y;
  } touch_report_t;

  // Predicts the scan reports from the accepted records and checks them.
  class scan_checker;
    logic             vertical;
    logic [DataW-1:0] off_x;
    logic [DataW-1:0] rat_x;
    logic [DataW-1:0] off_y;
    logic [DataW-1:0] rat_y;
    logic [SumW-1:0]  acc_x;
    logic [SumW-1:0]  acc_y;
    logic [CntW-1:0]  kept;
    touch_report_t    pending_reports[$];
    int               mismatches;
    int               reports_seen;
    int               scans_predicted;
    int               touches_predicted;

    function new();
      vertical = 1'b1;
      off_x = '0;
      rat_x = '0;
      off_y = '0;
      rat_y = '0;
      acc_x = '0;
      acc_y = '0;
      kept = '0;
      mismatches = 0;
      reports_seen = 0;
      scans_predicted = 0;
      touches_predicted = 0;
    endfunction

    // Mirrors one register write; unknown indexes change nothing.
    function void set_register(logic [CfgIdxW-1:0] idx, logic [DataW-1:0] val);
      case (idx)
        CFG_VERTICAL: vertical = val[0];
        CFG_OFFSET_X: off_x = val;
        CFG_RATIO_X:  rat_x = val;
        CFG_OFFSET_Y: off_y = val;
        CFG_RATIO_Y:  rat_y = val;
        default: ;
      endcase
    endfunction

    // ((avg << 16) - offset) / ratio with 32-bit wrap and truncation; a zero
    // ratio passes the average through. The quotient is formed at 64 bits so
    // that the most negative value over minus one wraps cleanly.
    function logic [DataW-1:0] scale_axis(logic [DataW-1:0] avg, logic [DataW-1:0] off,
                                          logic [DataW-1:0] rat);
      logic [DataW-1:0] num;
      longint           quo;
      if (rat == '0) return avg;
      num = (avg << FracBits) - off;
      quo = longint'($signed(num)) / longint'($signed(rat));
      return quo[DataW-1:0];
    endfunction

    // Takes an accepted record; returns 1 when it has any effect on the core.
    function bit note_record(point_rec_t r);
      logic [CoordW-1:0] raw_a;
      logic [CoordW-1:0] raw_b;
      logic [DataW-1:0]  avg_x;
      logic [DataW-1:0]  avg_y;
      touch_report_t     want;
      bit                effective;
      effective = r.last;
      if (r.xh[7:4] == EventContact && r.yh[7:4] != TouchIdNone &&
          kept < CntW'(MaxPoints)) begin
        raw_a = {r.xh[3:0], r.xl};
        raw_b = {r.yh[3:0], r.yl};
        if (vertical) begin
          acc_x = acc_x + SumW'(raw_a);
          acc_y = acc_y + SumW'(raw_b);
        end else begin
          acc_x = acc_x + SumW'(raw_b);
          acc_y = acc_y + SumW'(raw_a);
        end
        kept = kept + CntW'(1);
        effective = 1'b1;
      end
      if (!r.last) return effective;
      want.touched = 1'b0;
      want.pos_x = '0;
      want.pos_y = '0;
      if (r.fingers != '0 && r.fingers <= FingerMax && kept != '0) begin
        avg_x = DataW'(acc_x) / DataW'(kept);
        avg_y = DataW'(acc_y) / DataW'(kept);
        want.touched = 1'b1;
        want.pos_x = scale_axis(avg_x, off_x, rat_x);
        want.pos_y = scale_axis(avg_y, off_y, rat_y);
        touches_predicted++;
      end
      pending_reports.push_back(want);
      scans_predicted++;
      acc_x = '0;
      acc_y = '0;
      kept = '0;
      return effective;
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= PrintCap) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Compares an accepted report with the oldest prediction.
    task check_report(touch_report_t got);
      touch_report_t want;
      reports_seen++;
      if (pending_reports.size() == 0) begin
        report($sformatf("report with none expected: touched=%0b x=%0d y=%0d",
                         got.touched, got.pos_x, got.pos_y));
      end else begin
        want = pending_reports.pop_front();
        if (got.touched !== want.touched)
          report($sformatf("touched %0b, expected %0b", got.touched, want.touched));
        if (got.pos_x !== want.pos_x)
          report($sformatf("pos_x %0d, expected %0d", got.pos_x, want.pos_x));
        if (got.pos_y !== want.pos_y)
          report($sformatf("pos_y %0d, expected %0d", got.pos_y, want.pos_y));
      end
    endtask

    task close_out();
      if (pending_reports.size() != 0)
        report($sformatf("%0d expected reports never arrived", pending_reports.size()));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic rx_hold;

  tpdc_in_if  rec_if ();
  tpdc_out_if rep_if ();
  tpdc_cfg_if cfg_if ();

  scan_checker scans;
  int          records_sent;
  int          effective_items;
  int          longest_stall;
  int          settings_used;

  touch_point_decode_calibrate_core #(
    .MaxPoints(MaxPoints)
  ) u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (rec_if),
    .out_o (rep_if),
    .cfg_i (cfg_if)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run time limit.
  initial begin
    #(TimeLimitNs);
    $display("Run stopped at the time limit.");
    $display("*** FAILED ***");
    $finish;
  end

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Calibration word: extremes, plain random or a plausible 16.16 value.
  function automatic logic [DataW-1:0] pick_cal(bit is_ratio);
    logic [DataW-1:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'h8000_0000;
      1: v = 32'h7FFF_FFFF;
      2: v = '0;
      3: v = is_ratio ? 32'hFFFF_FFFF : 32'h0000_0001;
      4: v = $urandom;
      default: begin
        v = is_ratio ? $urandom_range(32'h0000_4000, 32'h0004_0000)
                     : $urandom_range(32'h0000_0000, 32'h0FFF_0000);
        if ($urandom_range(0, 3) == 0) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic point_rec_t make_rec(logic [ByteW-1:0] fingers, logic [ByteW-1:0] xh,
                                          logic [ByteW-1:0] xl, logic [ByteW-1:0] yh,
                                          logic [ByteW-1:0] yl, logic last);
    point_rec_t r;
    r.fingers = fingers;
    r.xh = xh;
    r.xl = xl;
    r.yh = yh;
    r.yl = yl;
    r.last = last;
    return r;
  endfunction

  // Random record: well formed ones are mostly kept contacts with a sane
  // finger count on the scan end; the others are plain noise.
  function automatic point_rec_t random_record(bit is_last, bit well_formed);
    point_rec_t r;
    r = make_rec(ByteW'($urandom), ByteW'($urandom), ByteW'($urandom), ByteW'($urandom),
                 ByteW'($urandom), is_last);
    if (!well_formed) return r;
    if (is_last) begin
      if ($urandom_range(0, 9) != 0) r.fingers = ByteW'($urandom_range(1, 5));
      else r.fingers = $urandom_range(0, 1) ? 8'd0 : ByteW'($urandom_range(6, 255));
    end
    if ($urandom_range(0, 6) != 0) r.xh = {EventContact, NibW'($urandom)};
    if ($urandom_range(0, 9) != 0) r.yh = {NibW'($urandom_range(0, 14)), NibW'($urandom)};
    else r.yh = {TouchIdNone, NibW'($urandom)};
    return r;
  endfunction

  // Offers one record after an idle gap and waits for its request to be taken.
  task automatic send_record(point_rec_t r, int gap);
    int waited;
    if (gap > 0) begin
      rec_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rec_if.valid        <= 1'b1;
    rec_if.finger_count <= r.fingers;
    rec_if.x_high_byte  <= r.xh;
    rec_if.x_low_byte   <= r.xl;
    rec_if.y_high_byte  <= r.yh;
    rec_if.y_low_byte   <= r.yl;
    rec_if.last_point   <= r.last;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (!rec_if.ready);
    if (waited > longest_stall) longest_stall = waited;
    records_sent++;
    if (scans.note_record(r)) effective_items++;
  endtask

  // Register write; the caller lowers valid after the last write of a batch.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [DataW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    scans.set_register(idx, val);
  endtask

  // Writes every register; the upper bits of the orientation word are junk.
  task automatic configure(logic vert, logic [DataW-1:0] ox, logic [DataW-1:0] rx,
                           logic [DataW-1:0] oy, logic [DataW-1:0] ry);
    write_reg(CFG_VERTICAL, {31'($urandom), vert});
    write_reg(CFG_OFFSET_X, ox);
    write_reg(CFG_RATIO_X, rx);
    write_reg(CFG_OFFSET_Y, oy);
    write_reg(CFG_RATIO_Y, ry);
    cfg_if.valid <= 1'b0;
    settings_used++;
  endtask

  // Waits until every predicted report has come back, then lets the core settle.
  task automatic drain();
    int guard;
    rec_if.valid <= 1'b0;
    guard = 0;
    while (scans.pending_reports.size() != 0 && guard < DrainLimit) begin
      @(posedge clk);
      guard++;
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  // One random scan, or now and then a single noise record.
  task automatic send_random_scan();
    int n;
    bit tight;
    if ($urandom_range(0, 9) < 2) begin
      send_record(random_record(1'($urandom_range(0, 1)), 1'b0), idle_len());
    end else begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 5) : $urandom_range(1, 2);
      tight = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n; i++)
        send_record(random_record(i == n - 1, 1'b1), tight ? 0 : idle_len());
    end
  endtask

  // Random scans until the target is met; optionally holds the receiver off
  // for a long stretch so that the core backs up into the record channel.
  task automatic run_random(int target, bit with_hold);
    int start_items;
    bit hold_done;
    start_items = effective_items;
    hold_done = 1'b0;
    while (effective_items - start_items < target) begin
      if (with_hold && !hold_done && effective_items - start_items >= 20) begin
        hold_done = 1'b1;
        fork
          begin
            rx_hold <= 1'b1;
            repeat (HoldCycles) @(posedge clk);
            rx_hold <= 1'b0;
          end
        join_none
      end
      send_random_scan();
    end
    // Close any scan left open so that the core ends the phase idle.
    send_record(random_record(1'b1, 1'b1), idle_len());
  endtask

  // Report receiver with random stalls and stretches of steady acceptance.
  initial begin
    touch_report_t got;
    int            stall;
    bit            eager;
    rep_if.ready <= 1'b0;
    stall = 0;
    eager = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (rep_if.valid && rep_if.ready) begin
        got.touched = rep_if.touched;
        got.pos_x = rep_if.pos_x;
        got.pos_y = rep_if.pos_y;
        scans.check_report(got);
      end
      if (rx_hold) begin
        rep_if.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        rep_if.ready <= 1'b0;
      end else if (eager) begin
        rep_if.ready <= 1'b1;
      end else begin
        stall = idle_len();
        rep_if.ready <= (stall == 0);
      end
      if ($urandom_range(0, 199) == 0) eager = !eager;
    end
  end

  // Main sequence.
  initial begin
    scans = new();
    records_sent = 0;
    effective_items = 0;
    longest_stall = 0;
    settings_used = 0;
    rst_n               <= 1'b0;
    rx_hold             <= 1'b0;
    rec_if.valid        <= 1'b0;
    rec_if.finger_count <= '0;
    rec_if.x_high_byte  <= '0;
    rec_if.x_low_byte   <= '0;
    rec_if.y_high_byte  <= '0;
    rec_if.y_low_byte   <= '0;
    rec_if.last_point   <= 1'b0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= '0;
    cfg_if.data         <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: raw axes kept, both axes passed through.
    send_record(make_rec(8'd1, {EventContact, 4'hF}, 8'hFF, 8'h00, 8'h00, 1'b1), idle_len());
    send_record(make_rec(8'd5, {EventContact, 4'h0}, 8'h00, 8'hEF, 8'hFF, 1'b1), idle_len());
    // Finger counts of zero and above five.
    send_record(make_rec(8'd0, {EventContact, 4'h1}, 8'h23, 8'h14, 8'h56, 1'b1), idle_len());
    send_record(make_rec(8'd6, {EventContact, 4'h1}, 8'h23, 8'h14, 8'h56, 1'b1), idle_len());
    send_record(make_rec(8'hFF, {EventContact, 4'h1}, 8'h23, 8'h14, 8'h56, 1'b1), idle_len());
    // No kept contact: wrong event flag, then the empty touch id.
    send_record(make_rec(8'd1, 8'h4A, 8'h55, 8'h2A, 8'hAA, 1'b1), idle_len());
    send_record(make_rec(8'd1, {EventContact, 4'h7}, 8'h77, {TouchIdNone, 4'h7}, 8'h77, 1'b1),
                idle_len());
    // Overlong scan: contacts beyond the limit are dropped.
    send_record(make_rec(8'hFF, {EventContact, 4'h1}, 8'h23, 8'h04, 8'h56, 1'b0), 0);
    send_record(make_rec(8'd2, {EventContact, 4'hA}, 8'hBC, 8'h1D, 8'hEF, 1'b1), 0);
    // Contact early in the scan, nothing usable on its last record.
    send_record(make_rec(8'd3, {EventContact, 4'h3}, 8'h33, 8'h20, 8'h44, 1'b0), idle_len());
    send_record(make_rec(8'd3, 8'h2F, 8'hFF, 8'h3F, 8'hFF, 1'b1), idle_len());
    send_record(make_rec(8'd1, 8'h8F, 8'hFF, 8'hFF, 8'hFF, 1'b0), idle_len());
    send_record(make_rec(8'd4, {EventContact, 4'h0}, 8'h01, 8'h00, 8'h02, 1'b1), idle_len());
    drain();

    // Writes to indexes past the register list, then swapped axes with the
    // most negative x offset over minus one, so x divides into overflow.
    write_reg(CfgIdxSpare, 32'hDEAD_BEEF);
    write_reg(CfgIdxTop, 32'h1234_5678);
    configure(1'b0, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_record(make_rec(8'd2, {EventContact, 4'hA}, 8'hBC, 8'h00, 8'h00, 1'b1), idle_len());
    send_record(make_rec(8'd5, 8'h8F, 8'hFF, 8'h0F, 8'hFF, 1'b1), idle_len());
    drain();

    configure(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h0000_0001);
    send_record(make_rec(8'd1, 8'h80, 8'h00, 8'h00, 8'h00, 1'b1), idle_len());
    send_record(make_rec(8'd1, 8'h8F, 8'hFF, 8'h0F, 8'hFF, 1'b1), idle_len());
    send_record(make_rec(8'd3, {EventContact, 4'h8}, 8'h00, 8'h58, 8'h00, 1'b1), idle_len());
    drain();

    // Random phases, each under fresh settings; the first holds the receiver.
    for (int p = 0; p < RandomPhases; p++) begin
      configure(1'($urandom_range(0, 1)), pick_cal(1'b0), pick_cal(1'b1), pick_cal(1'b0),
                pick_cal(1'b1));
      run_random(RandomPerPhase, p == 0);
      drain();
    end

    scans.close_out();
    $display("Covered %0d point records over %0d scans, %0d with a touch, under %0d settings.",
             records_sent, scans.scans_predicted, scans.touches_predicted, settings_used);
    $display("Checked %0d reports; longest record stall %0d cycles; %0d mismatches.",
             scans.reports_seen, longest_stall, scans.mismatches);
    if (scans.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
